/* sv/lionu_pkg.sv */
// Shared types, register codes and fixed-point helpers for the Lion optimizer update block.
// Depends on nothing; every other file of the block but lionu_ram imports it.

package lionu_pkg;

   // Configuration register codes (index on the csr port).
   localparam logic [7:0] CSR_STEP_SIZE     = 8'd0;
   localparam logic [7:0] CSR_BETA_ONE      = 8'd1;
   localparam logic [7:0] CSR_BETA_TWO      = 8'd2;
   localparam logic [7:0] CSR_WEIGHT_DECAY  = 8'd3;

   // Register reset values (Q0.16 weights).
   localparam logic [15:0] LR_RESET = 16'd66;
   localparam logic [15:0] B1_RESET = 16'd58982;
   localparam logic [15:0] B2_RESET = 16'd65470;
   localparam logic [15:0] WD_RESET = 16'd655;

   // Weights carry 16 fraction bits; products are scaled back by this shift.
   localparam int WGT_SHIFT = 16;

   // Queue between front and back.
   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = 2;
   localparam int FQ_CNT_W = 3;

   // Result queue.
   localparam int RSPQ_DEPTH = 8;
   localparam int RSPQ_PTR_W = 3;
   localparam int RSPQ_CNT_W = 4;

   typedef struct packed {
      logic [15:0] step_size;
      logic [15:0] beta_one;
      logic [15:0] beta_two;
      logic [15:0] weight_decay;
   } cfg_type;

   // Item as it leaves the front, already classified.
   typedef struct packed {
      logic               in_range;
      logic [7:0]         index;
      logic signed [31:0] gradient;
   } qitem_type;

   typedef struct packed {
      logic [7:0]         out_index;
      logic signed [31:0] new_value;
      logic signed [1:0]  direction;
   } rsp_type;

   // Saturate a wide signed value to the 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sh0000_0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

/* sv/lionu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module lionu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port; the read returns the old word when both hit one address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/lionu_front.sv */
// Front end: accepts items, classifies the index against the store depth and queues them.
// Depends on lionu_pkg.

module lionu_front import lionu_pkg::*; #(
   parameter int NUM_PARAMS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_index,
   input  logic signed [31:0] req_gradient,
   input  logic               busy,
   output logic               q_valid,
   output qitem_type          q_item,
   input  logic               q_pop
);

   qitem_type             entry_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FQ_CNT_W-1:0]   count_ff, count_in;
   logic                  accept;
   qitem_type             new_item;

   // An item is taken while the queue has room and the stores are not being cleared.
   assign full   = busy | (count_ff == FQ_CNT_W'(FQ_DEPTH));
   assign accept = push & ~full;

   // Classify: an index past the store depth leaves the stores untouched.
   always_comb begin
      new_item.in_range = ({24'd0, req_index} < 32'(NUM_PARAMS));
      new_item.index    = req_index;
      new_item.gradient = req_gradient;
   end

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (accept && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];

endmodule

/* sv/lionu_rspq.sv */
// Result queue that decouples the update pipeline from the consumer.
// Depends on lionu_pkg.

module lionu_rspq import lionu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  rsp_type               wr_item,
   input  logic                  pop,
   output logic                  empty,
   output rsp_type               head,
   output logic [RSPQ_CNT_W-1:0] level
);

   rsp_type                 entry_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0]   count_ff, count_in;
   logic                    take;

   assign empty = (count_ff == '0);
   assign take  = pop & ~empty;

   // Pointer and fill bookkeeping; the back end never writes into a full queue.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (wr_en && !take) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign level = count_ff;

endmodule

/* sv/lionu_back.sv */
// Back end: reads the stores, runs the four-stage Lion update and writes the stores back.
// Depends on lionu_pkg and lionu_ram; feeds lionu_rspq.

module lionu_back import lionu_pkg::*; #(
   parameter int NUM_PARAMS = 256,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_valid,
   input  qitem_type             q_item,
   output logic                  q_pop,
   input  logic [RSPQ_CNT_W-1:0] rsp_level,
   output logic                  rsp_wr,
   output rsp_type               rsp_item,
   output logic                  busy
);

   localparam int ADDR_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

   // Clearing pass after reset.
   logic              clr_ff, clr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // Issue.
   logic [ADDR_W+7:0] head_ext;
   logic [ADDR_W-1:0] head_addr, rd_addr;
   logic              hazard, room, issue;
   logic [2:0]        inflight;

   // Stage registers.
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   qitem_type          it1_ff, it2_ff, it3_ff, it4_ff;
   logic [ADDR_W-1:0]  a1_ff, a2_ff, a3_ff, a4_ff;
   logic signed [31:0] p2_ff, p3_ff, p4_ff;
   logic signed [49:0] ca2_ff, cb2_ff, ma2_ff, mb2_ff, pd2_ff;
   logic signed [35:0] d3_ff;
   logic signed [1:0]  dir3_ff, dir4_ff;
   logic signed [52:0] prod4_ff;

   // Stage 1 terms.
   logic signed [31:0] mom_rd, par_rd;
   logic signed [17:0] b1_s, nb1_s, b2_s, nb2_s, wd_s;
   logic signed [49:0] ca1, cb1, ma1, mb1, pd1;

   // Stage 2 terms.
   logic signed [50:0] c_sum, m_sum, pd_rnd, m_rnd;
   logic signed [34:0] dterm, m_shift;
   logic signed [1:0]  dir2;
   logic signed [35:0] d2;
   logic signed [31:0] mom_new;

   // Stage 3 and 4 terms.
   logic signed [16:0] lr_s;
   logic signed [52:0] prod3;
   logic signed [53:0] step_rnd;
   logic signed [37:0] step;
   logic signed [31:0] par_new;

   // Store ports.
   logic              mom_we, par_we;
   logic [ADDR_W-1:0] mom_wa, par_wa;
   logic [31:0]       mom_wd, par_wd;
   logic [31:0]       mom_rd_raw, par_rd_raw;

   // Zero both stores after reset, walking the entries in address order.
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         if (clr_addr_ff == ADDR_W'(NUM_PARAMS - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign busy = clr_ff;

   // Issue the queue head unless an in-flight item still owes a write to its entry,
   // or the result queue could not take every item already in flight.
   assign head_ext  = {{ADDR_W{1'b0}}, q_item.index};
   assign head_addr = head_ext[ADDR_W-1:0];
   assign rd_addr   = q_item.in_range ? head_addr : '0;

   always_comb begin
      hazard = 1'b0;
      if (q_item.in_range) begin
         hazard = (v1_ff && it1_ff.in_range && a1_ff == head_addr) ||
                  (v2_ff && it2_ff.in_range && a2_ff == head_addr) ||
                  (v3_ff && it3_ff.in_range && a3_ff == head_addr) ||
                  (v4_ff && it4_ff.in_range && a4_ff == head_addr);
      end
      inflight = 3'(v1_ff) + 3'(v2_ff) + 3'(v3_ff) + 3'(v4_ff);
      room     = (RSPQ_CNT_W'(inflight) + rsp_level) < RSPQ_CNT_W'(RSPQ_DEPTH);
      issue    = q_valid & ~hazard & room & ~clr_ff;
   end

   assign q_pop = issue;

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Stage 1: store words arrive; form the five weighted products.
   assign mom_rd = $signed(mom_rd_raw);
   assign par_rd = $signed(par_rd_raw);
   assign b1_s   = $signed({2'b00, cfg.beta_one});
   assign nb1_s  = 18'sd65536 - b1_s;
   assign b2_s   = $signed({2'b00, cfg.beta_two});
   assign nb2_s  = 18'sd65536 - b2_s;
   assign wd_s   = $signed({2'b00, cfg.weight_decay});
   assign ca1    = b1_s * mom_rd;
   assign cb1    = nb1_s * it1_ff.gradient;
   assign ma1    = b2_s * mom_rd;
   assign mb1    = nb2_s * it1_ff.gradient;
   assign pd1    = wd_s * par_rd;

   // Stage 2: sign of the interpolation, decay term and new momentum.
   always_comb begin
      c_sum   = 51'(ca2_ff) + 51'(cb2_ff);
      dir2    = (c_sum > 0) ? 2'sd1 : ((c_sum < 0) ? -2'sd1 : 2'sd0);
      pd_rnd  = 51'(pd2_ff) + (51'sd1 <<< (WGT_SHIFT - 1));
      dterm   = 35'(pd_rnd >>> WGT_SHIFT);
      d2      = (36'(dir2) <<< FRAC_BITS) + 36'(dterm);
      m_sum   = 51'(ma2_ff) + 51'(mb2_ff);
      m_rnd   = m_sum + (51'sd1 <<< (WGT_SHIFT - 1));
      m_shift = 35'(m_rnd >>> WGT_SHIFT);
      mom_new = sat32(64'(m_shift));
   end

   // Stage 3: scale by the learning rate.
   assign lr_s  = $signed({1'b0, cfg.step_size});
   assign prod3 = lr_s * d3_ff;

   // Stage 4: round the step and subtract it from the parameter.
   always_comb begin
      step_rnd = 54'(prod4_ff) + (54'sd1 <<< (WGT_SHIFT - 1));
      step     = 38'(step_rnd >>> WGT_SHIFT);
      par_new  = sat32(64'(p4_ff) - 64'(step));
   end

   // Payload pipeline.
   always_ff @(posedge clock) begin
      it1_ff   <= q_item;
      a1_ff    <= head_addr;
      it2_ff   <= it1_ff;
      a2_ff    <= a1_ff;
      p2_ff    <= par_rd;
      ca2_ff   <= ca1;
      cb2_ff   <= cb1;
      ma2_ff   <= ma1;
      mb2_ff   <= mb1;
      pd2_ff   <= pd1;
      it3_ff   <= it2_ff;
      a3_ff    <= a2_ff;
      p3_ff    <= p2_ff;
      d3_ff    <= d2;
      dir3_ff  <= dir2;
      it4_ff   <= it3_ff;
      a4_ff    <= a3_ff;
      p4_ff    <= p3_ff;
      dir4_ff  <= dir3_ff;
      prod4_ff <= prod3;
   end

   // Store writes: momentum from stage 2, parameter from stage 4, zeros while clearing.
   assign mom_we = clr_ff | (v2_ff & it2_ff.in_range);
   assign mom_wa = clr_ff ? clr_addr_ff : a2_ff;
   assign mom_wd = clr_ff ? 32'd0 : mom_new;
   assign par_we = clr_ff | (v4_ff & it4_ff.in_range);
   assign par_wa = clr_ff ? clr_addr_ff : a4_ff;
   assign par_wd = clr_ff ? 32'd0 : par_new;

   lionu_ram #(.WIDTH(32), .DEPTH(NUM_PARAMS)) u_mom_ram (
      .clock   (clock),
      .wr_en   (mom_we),
      .wr_addr (mom_wa),
      .wr_data (mom_wd),
      .rd_addr (rd_addr),
      .rd_data (mom_rd_raw)
   );

   lionu_ram #(.WIDTH(32), .DEPTH(NUM_PARAMS)) u_par_ram (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_wa),
      .wr_data (par_wd),
      .rd_addr (rd_addr),
      .rd_data (par_rd_raw)
   );

   // Result; an out-of-range index reports zero value and zero direction.
   always_comb begin
      rsp_wr             = v4_ff;
      rsp_item.out_index = it4_ff.index;
      rsp_item.new_value = it4_ff.in_range ? par_new : 32'sd0;
      rsp_item.direction = it4_ff.in_range ? dir4_ff : 2'sd0;
   end

endmodule

/* sv/lion_optimizer_update.sv */
// Top level of the Lion optimizer update block: configuration registers, front, back, result queue.
// Depends on lionu_pkg, lionu_front, lionu_back and lionu_rspq.

// One gradient item per clock enters and one result per clock leaves in steady state, while the
// consumer keeps popping and no item waits on its index. Each item passes the store read and
// weighted products, sign and momentum, learning-rate multiply, and rounding and write-back stages
// after a short input queue; its result then sits in an eight-entry result queue until popped. An
// item whose index matches one still in the pipeline waits until that entry has been written back,
// so consecutive items on one index cannot enter back to back. After reset the parameter and momentum
// stores are cleared one entry per cycle, which holds full high until the last entry is cleared;
// configuration writes are taken during that time. Registers should be written only while no item is in flight.

module lion_optimizer_update import lionu_pkg::*; #(
   parameter int NUM_PARAMS = 256,
   parameter int FRAC_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_index,
   input  logic signed [31:0] req_gradient,
   output logic               empty,
   input  logic               pop,
   output logic [7:0]         rsp_out_index,
   output logic signed [31:0] rsp_new_value,
   output logic signed [1:0]  rsp_direction,
   input  logic               csr_we,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   cfg_type                 cfg_ff, cfg_in;
   logic                    busy;
   logic                    q_valid, q_pop;
   qitem_type               q_item;
   logic                    rsp_wr;
   rsp_type                 rsp_item, rsp_head;
   logic [RSPQ_CNT_W-1:0]   rsp_level;

   // Register decode; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_SIZE:     cfg_in.step_size     = csr_wdata;
            CSR_BETA_ONE:      cfg_in.beta_one      = csr_wdata;
            CSR_BETA_TWO:      cfg_in.beta_two      = csr_wdata;
            CSR_WEIGHT_DECAY:  cfg_in.weight_decay  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size     <= LR_RESET;
         cfg_ff.beta_one      <= B1_RESET;
         cfg_ff.beta_two      <= B2_RESET;
         cfg_ff.weight_decay  <= WD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept and classify.
   lionu_front #(.NUM_PARAMS(NUM_PARAMS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_index    (req_index),
      .req_gradient (req_gradient),
      .busy         (busy),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop)
   );

   // Update pipeline and stores.
   lionu_back #(.NUM_PARAMS(NUM_PARAMS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_level (rsp_level),
      .rsp_wr    (rsp_wr),
      .rsp_item  (rsp_item),
      .busy      (busy)
   );

   // Results wait here for the consumer.
   lionu_rspq u_rspq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_wr),
      .wr_item (rsp_item),
      .pop     (pop),
      .empty   (empty),
      .head    (rsp_head),
      .level   (rsp_level)
   );

   assign rsp_out_index = rsp_head.out_index;
   assign rsp_new_value = rsp_head.new_value;
   assign rsp_direction = rsp_head.direction;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the Lion optimizer update block: queue-style item and result
// channels, a plain register write port, and a predictor that tracks both stores.
// Depends on lionu_pkg and lion_optimizer_update.

module testbench import lionu_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PARAM_COUNT = 256;
   localparam int Q_FRAC = 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 16;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 100;

   // Register values after reset, as the block documents them.
   localparam logic [15:0] DEF_STEP_SIZE = 16'd66;
   localparam logic [15:0] DEF_BETA_ONE = 16'd58982;
   localparam logic [15:0] DEF_BETA_TWO = 16'd65470;
   localparam logic [15:0] DEF_WEIGHT_DECAY = 16'd655;

   localparam logic [7:0] CSR_FIRST_UNUSED = CSR_WEIGHT_DECAY + 8'd1;
   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;
   localparam logic signed [31:0] GRAD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] GRAD_MIN = 32'sh8000_0000;

   typedef struct {
      logic [7:0]         index;
      logic signed [31:0] value;
      logic signed [1:0]  dir;
   } param_update_type;

   logic               clock;
   logic               reset;
   logic               push;
   logic               full;
   logic [7:0]         req_index;
   logic signed [31:0] req_gradient;
   logic               empty;
   logic               pop;
   logic [7:0]         rsp_out_index;
   logic signed [31:0] rsp_new_value;
   logic signed [1:0]  rsp_direction;
   logic               csr_we;
   logic [7:0]         csr_index;
   logic [15:0]        csr_wdata;

   // Predictor state: a copy of the registers and both stores.
   logic [15:0] lr_q;
   logic [15:0] b1_q;
   logic [15:0] b2_q;
   logic [15:0] wd_q;
   int param_mem [PARAM_COUNT];
   int momentum_mem [PARAM_COUNT];

   param_update_type expected_updates [$];
   int errors;
   int cycle_count;
   int stall_left;
   int hold_left;
   bit sender_idles;
   bit receiver_idles;

   lion_optimizer_update #(
      .NUM_PARAMS(PARAM_COUNT),
      .FRAC_BITS(Q_FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_index(req_index),
      .req_gradient(req_gradient),
      .empty(empty),
      .pop(pop),
      .rsp_out_index(rsp_out_index),
      .rsp_new_value(rsp_new_value),
      .rsp_direction(rsp_direction),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Round a Q.16 product back by 16 bits, halves going toward plus infinity.
   function automatic longint round_q16(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic int clamp_word(input longint x);
      int r;
      if (x > WORD_MAX) begin
         r = int'(WORD_MAX);
      end else if (x < WORD_MIN) begin
         r = int'(WORD_MIN);
      end else begin
         r = int'(x);
      end
      return r;
   endfunction

   // Apply one gradient to the predicted stores and queue the expected result.
   task automatic predict_update(input logic [7:0] idx, input logic signed [31:0] grad);
      param_update_type upd;
      longint g;
      longint m;
      longint p;
      longint c;
      longint d;
      longint step_amt;
      longint mn;
      int dir;
      int new_param;
      g = grad;
      upd.index = idx;
      upd.value = '0;
      upd.dir = '0;
      if (int'(idx) < PARAM_COUNT) begin
         m = momentum_mem[idx];
         p = param_mem[idx];
         c = longint'(b1_q) * m + (64'sd65536 - longint'(b1_q)) * g;
         dir = (c > 0) ? 1 : ((c < 0) ? -1 : 0);
         d = longint'(dir) * (64'sd1 << Q_FRAC) + round_q16(longint'(wd_q) * p);
         step_amt = round_q16(longint'(lr_q) * d);
         new_param = clamp_word(p - step_amt);
         param_mem[idx] = new_param;
         mn = longint'(b2_q) * m + (64'sd65536 - longint'(b2_q)) * g;
         momentum_mem[idx] = clamp_word(round_q16(mn));
         upd.value = new_param;
         upd.dir = dir[1:0];
      end
      expected_updates.push_back(upd);
   endtask

   // Offer one item after an optional gap; returns at the falling edge after acceptance.
   task automatic send_item(input logic [7:0] idx, input logic signed [31:0] grad);
      int gap;
      gap = sender_idles ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_index <= idx;
      req_gradient <= grad;
      do @(posedge clock); while (full !== 1'b0);
      predict_update(idx, grad);
      @(negedge clock);
   endtask

   // Stop offering items and wait until every expected result has been taken.
   task automatic wait_for_results();
      push <= 1'b0;
      while (expected_updates.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write all four registers, then a register index the block does not decode.
   task automatic apply_config(input logic [15:0] lr, input logic [15:0] b1,
                               input logic [15:0] b2, input logic [15:0] wd);
      logic [7:0] codes [4];
      logic [15:0] values [4];
      codes = '{CSR_STEP_SIZE, CSR_BETA_ONE, CSR_BETA_TWO, CSR_WEIGHT_DECAY};
      values = '{lr, b1, b2, wd};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= codes[i];
         csr_wdata <= values[i];
         @(negedge clock);
      end
      lr_q = lr;
      b1_q = b1;
      b2_q = b2;
      wd_q = wd;
      // Writes past the last register must leave every register alone.
      csr_index <= 8'($urandom_range(CSR_FIRST_UNUSED, 255));
      csr_wdata <= 16'($urandom());
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] pick_weight();
      logic [15:0] w;
      case ($urandom_range(0, 3))
         0: w = 16'd0;
         1: w = 16'hFFFF;
         default: w = 16'($urandom_range(0, 65535));
      endcase
      return w;
   endfunction

   function automatic logic signed [31:0] random_gradient();
      logic signed [31:0] g;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0: g = GRAD_MAX;
               1: g = GRAD_MIN;
               2: g = 32'sd0;
               3: g = 32'sd1;
               default: g = -32'sd1;
            endcase
         end
         1: g = int'($urandom_range(0, 131072)) - 65536;
         2: g = int'($urandom_range(0, 1 << 24)) - 8388608;
         default: g = $urandom();
      endcase
      return g;
   endfunction

   // Directed items under the reset register values, including a zero direction.
   task automatic test_reset_defaults();
      sender_idles = 1'b0;
      receiver_idles = 1'b1;
      send_item(8'd0, 32'sd0);
      send_item(8'd255, GRAD_MAX);
      send_item(8'd1, GRAD_MIN);
      send_item(8'd255, GRAD_MIN);
      send_item(8'd128, 32'sd1);
      send_item(8'd127, -32'sd1);
      // Back-to-back items on one index must see each other's write-back.
      repeat (3) send_item(8'd7, 32'sd65536);
      wait_for_results();
   endtask

   // Directed items at the register extremes and with an exact cancellation.
   task automatic test_weight_extremes();
      apply_config(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
      repeat (3) send_item(8'd20, GRAD_MAX);
      repeat (3) send_item(8'd21, GRAD_MIN);
      send_item(8'd20, 32'sd0);
      wait_for_results();
      // Equal weights and opposite values give an interpolation of exactly zero.
      apply_config(16'hFFFF, 16'd32768, 16'd0, 16'd0);
      send_item(8'd30, 32'sd5);
      send_item(8'd30, -32'sd5);
      send_item(8'd30, 32'sd0);
      wait_for_results();
      apply_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      send_item(8'd40, GRAD_MAX);
      send_item(8'd40, GRAD_MIN);
      wait_for_results();
   endtask

   // Random phases, each under its own register setting and idling pattern.
   task automatic test_random_updates(input int phases, input int items_per_phase);
      logic [7:0] hot_set [4];
      logic [7:0] idx;
      for (int ph = 0; ph < phases; ph++) begin
         if (ph == 0) begin
            apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         end else if (ph == 1) begin
            apply_config(16'd0, 16'd0, 16'd0, 16'd0);
         end else begin
            apply_config(pick_weight(), pick_weight(), pick_weight(), pick_weight());
         end
         foreach (hot_set[i]) hot_set[i] = 8'($urandom_range(0, 255));
         sender_idles = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < items_per_phase; n++) begin
            // Mostly a few hot entries so the stores build up real history.
            if ($urandom_range(0, 2) == 0) begin
               idx = 8'($urandom_range(0, 255));
            end else begin
               idx = hot_set[$urandom_range(0, 3)];
            end
            send_item(idx, random_gradient());
         end
         wait_for_results();
      end
   endtask

   // Hold the result side off long enough that the block fills and stalls its input.
   task automatic test_result_backpressure();
      apply_config(pick_weight(), pick_weight(), pick_weight(), pick_weight());
      sender_idles = 1'b0;
      receiver_idles = 1'b1;
      @(posedge clock);
      hold_left = LONG_HOLD_CYCLES;
      @(negedge clock);
      for (int n = 0; n < 40; n++) begin
         send_item(8'($urandom_range(0, 255)), random_gradient());
      end
      wait_for_results();
   endtask

   // Full rate on both sides with a tiny index set, so hazards follow each other closely.
   task automatic test_full_rate();
      apply_config(pick_weight(), pick_weight(), pick_weight(), pick_weight());
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      for (int n = 0; n < 50; n++) begin
         send_item(8'($urandom_range(60, 62)), random_gradient());
      end
      wait_for_results();
   endtask

   // Result checker: compare each taken result with the oldest expectation.
   always @(posedge clock) begin : check_results
      param_update_type want;
      if (!reset && pop === 1'b1 && empty === 1'b0) begin
         if (expected_updates.size() == 0) begin
            if (errors < MAX_REPORTS) begin
               $display("%0t: unexpected result, expected none, actual index %0d value %0d",
                        $time, rsp_out_index, rsp_new_value);
            end
            errors++;
         end else begin
            want = expected_updates.pop_front();
            if (rsp_out_index !== want.index) begin
               if (errors < MAX_REPORTS) begin
                  $display("%0t: out_index expected %0d actual %0d",
                           $time, want.index, rsp_out_index);
               end
               errors++;
            end
            if (rsp_new_value !== want.value) begin
               if (errors < MAX_REPORTS) begin
                  $display("%0t: new_value (index %0d) expected %0d actual %0d",
                           $time, want.index, want.value, rsp_new_value);
               end
               errors++;
            end
            if (rsp_direction !== want.dir) begin
               if (errors < MAX_REPORTS) begin
                  $display("%0t: direction (index %0d) expected %0d actual %0d",
                           $time, want.index, want.dir, rsp_direction);
               end
               errors++;
            end
         end
         stall_left = receiver_idles ? $urandom_range(0, 19) : 0;
      end
   end

   // Result side: pop unless a random stall or a long hold is running.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         pop <= 1'b0;
         stall_left--;
      end else begin
         pop <= 1'b1;
      end
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, CYCLE_LIMIT, expected_updates.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      push = 1'b0;
      req_index = '0;
      req_gradient = '0;
      pop = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      stall_left = 0;
      hold_left = 0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      lr_q = DEF_STEP_SIZE;
      b1_q = DEF_BETA_ONE;
      b2_q = DEF_BETA_TWO;
      wd_q = DEF_WEIGHT_DECAY;
      foreach (param_mem[i]) begin
         param_mem[i] = 0;
         momentum_mem[i] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_weight_extremes();
      test_random_updates(6, 270);
      test_result_backpressure();
      test_full_rate();

      wait_for_results();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* lion_optimizer_update.f */
sv/lionu_pkg.sv
sv/lionu_ram.sv
sv/lionu_front.sv
sv/lionu_rspq.sv
sv/lionu_back.sv
sv/lion_optimizer_update.sv
tb/sv/testbench.sv
